FILE: rtl/core/sot_pkg.sv
// ----------------------------------------------------------------------------
// sot_pkg
// Shared types and constants for the segment occlusion test core.
// ----------------------------------------------------------------------------
package sot_pkg;

   localparam int MaxWalls = 1024;
   localparam int AddrW    = $clog2(MaxWalls);
   localparam int CountW   = $clog2(MaxWalls + 1);

   localparam logic [1:0] MODE_CLEAR  = 2'd0;
   localparam logic [1:0] MODE_APPEND = 2'd1;
   localparam logic [1:0] MODE_QUERY  = 2'd2;
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   typedef struct packed {
      logic [1:0]         mode;
      logic signed [15:0] coord_ax;
      logic signed [15:0] coord_ay;
      logic signed [15:0] coord_bx;
      logic signed [15:0] coord_by;
      logic [15:0]        wall_flags;
      logic [15:0]        wall_kind;
   } req_type;

   typedef struct packed {
      logic        visible;
      logic [10:0] walls_stored;
      logic        table_full;
   } rsp_type;

   typedef struct packed {
      logic signed [15:0] x1;
      logic signed [15:0] y1;
      logic signed [15:0] x2;
      logic signed [15:0] y2;
   } seg_type;

endpackage

FILE: rtl/core/sot_wall_ram.sv
// ----------------------------------------------------------------------------
// sot_wall_ram
// Wall table: one write port, one registered read port.
// ----------------------------------------------------------------------------
module sot_wall_ram
   import sot_pkg::*;
(
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AddrW-1:0] wr_addr,
   input  seg_type          wr_data,
   input  logic [AddrW-1:0] rd_addr,
   output seg_type          rd_data
);

   seg_type mem [MaxWalls];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

FILE: rtl/core/sot_hit_pipe.sv
// ----------------------------------------------------------------------------
// sot_hit_pipe
// Pipelined exact segment intersection test, one wall per cycle.
// ----------------------------------------------------------------------------
module sot_hit_pipe
   import sot_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   input  seg_type wall,
   input  seg_type sight,
   output logic    out_valid,
   output logic    out_hit
);

   // stage 1: differences
   logic         s1_v_ff;
   logic signed [16:0] dx1_ff, dy1_ff, dx3_ff, dy3_ff;
   seg_type      w1_ff, v1_ff;
   // stage 2: products
   logic         s2_v_ff;
   logic signed [33:0] dA_ff, dB_ff;
   logic signed [32:0] c1a_ff, c1b_ff, c2a_ff, c2b_ff;
   logic signed [16:0] dx1b_ff, dy1b_ff, dx3b_ff, dy3b_ff;
   seg_type      w2_ff, v2_ff;
   // stage 3: sums
   logic         s3_v_ff;
   logic signed [34:0] d_ff;
   logic signed [33:0] c1_ff, c2_ff;
   logic signed [16:0] dx1c_ff, dy1c_ff, dx3c_ff, dy3c_ff;
   seg_type      w3_ff, v3_ff;
   // stage 4: numerator products
   logic         s4_v_ff;
   logic signed [34:0] d4_ff;
   logic signed [51:0] p1_ff, p2_ff, p3_ff, p4_ff;
   seg_type      w4_ff, v4_ff;
   // stage 5: numerators, sign normalize
   logic         s5_v_ff, s5_nz_ff;
   logic signed [53:0] nx_ff, ny_ff;
   logic signed [35:0] d5_ff;
   seg_type      w5_ff, v5_ff;
   // stage 6: box bound products
   logic         s6_v_ff, s6_nz_ff;
   logic signed [53:0] nx6_ff, ny6_ff;
   logic signed [53:0] lx3_ff, hx3_ff, ly3_ff, hy3_ff, lx1_ff, hx1_ff, ly1_ff, hy1_ff;
   // stage 7: compare
   logic         s7_v_ff, s7_hit_ff;

   logic signed [53:0] nx_w, ny_w;
   logic signed [35:0] d_w;

   function automatic logic signed [15:0] lo16(logic signed [15:0] a,
                                               logic signed [15:0] b);
      return (a < b) ? a : b;
   endfunction
   function automatic logic signed [15:0] hi16(logic signed [15:0] a,
                                               logic signed [15:0] b);
      return (a < b) ? b : a;
   endfunction

   always_comb begin
      nx_w = 54'(p1_ff) - 54'(p2_ff);
      ny_w = 54'(p3_ff) - 54'(p4_ff);
      d_w  = 36'(d4_ff);
      if (d4_ff < 0) begin
         nx_w = -nx_w;
         ny_w = -ny_w;
         d_w  = -d_w;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0; s2_v_ff <= 1'b0; s3_v_ff <= 1'b0;
         s4_v_ff <= 1'b0; s5_v_ff <= 1'b0; s6_v_ff <= 1'b0; s7_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= in_valid; s2_v_ff <= s1_v_ff; s3_v_ff <= s2_v_ff;
         s4_v_ff <= s3_v_ff; s5_v_ff <= s4_v_ff; s6_v_ff <= s5_v_ff;
         s7_v_ff <= s6_v_ff;
      end
      dx1_ff <= 17'(wall.x1) - 17'(wall.x2);
      dy1_ff <= 17'(wall.y1) - 17'(wall.y2);
      dx3_ff <= 17'(sight.x1) - 17'(sight.x2);
      dy3_ff <= 17'(sight.y1) - 17'(sight.y2);
      w1_ff <= wall; v1_ff <= sight;

      dA_ff  <= dx1_ff * dy3_ff;
      dB_ff  <= dy1_ff * dx3_ff;
      c1a_ff <= w1_ff.x1 * w1_ff.y2;
      c1b_ff <= w1_ff.y1 * w1_ff.x2;
      c2a_ff <= v1_ff.x1 * v1_ff.y2;
      c2b_ff <= v1_ff.y1 * v1_ff.x2;
      dx1b_ff <= dx1_ff; dy1b_ff <= dy1_ff; dx3b_ff <= dx3_ff; dy3b_ff <= dy3_ff;
      w2_ff <= w1_ff; v2_ff <= v1_ff;

      d_ff  <= 35'(dA_ff) - 35'(dB_ff);
      c1_ff <= 34'(c1a_ff) - 34'(c1b_ff);
      c2_ff <= 34'(c2a_ff) - 34'(c2b_ff);
      dx1c_ff <= dx1b_ff; dy1c_ff <= dy1b_ff; dx3c_ff <= dx3b_ff; dy3c_ff <= dy3b_ff;
      w3_ff <= w2_ff; v3_ff <= v2_ff;

      d4_ff <= d_ff;
      p1_ff <= c1_ff * dx3c_ff;
      p2_ff <= dx1c_ff * c2_ff;
      p3_ff <= c1_ff * dy3c_ff;
      p4_ff <= dy1c_ff * c2_ff;
      w4_ff <= w3_ff; v4_ff <= v3_ff;

      s5_nz_ff <= (d4_ff != 0);
      nx_ff <= nx_w; ny_ff <= ny_w; d5_ff <= d_w;
      w5_ff <= w4_ff; v5_ff <= v4_ff;

      s6_nz_ff <= s5_nz_ff;
      nx6_ff <= nx_ff; ny6_ff <= ny_ff;
      lx3_ff <= 54'(lo16(v5_ff.x1, v5_ff.x2) * d5_ff);
      hx3_ff <= 54'(hi16(v5_ff.x1, v5_ff.x2) * d5_ff);
      ly3_ff <= 54'(lo16(v5_ff.y1, v5_ff.y2) * d5_ff);
      hy3_ff <= 54'(hi16(v5_ff.y1, v5_ff.y2) * d5_ff);
      lx1_ff <= 54'(lo16(w5_ff.x1, w5_ff.x2) * d5_ff);
      hx1_ff <= 54'(hi16(w5_ff.x1, w5_ff.x2) * d5_ff);
      ly1_ff <= 54'(lo16(w5_ff.y1, w5_ff.y2) * d5_ff);
      hy1_ff <= 54'(hi16(w5_ff.y1, w5_ff.y2) * d5_ff);

      s7_hit_ff <= s6_nz_ff &&
                   nx6_ff >= lx3_ff && nx6_ff <= hx3_ff &&
                   ny6_ff >= ly3_ff && ny6_ff <= hy3_ff &&
                   nx6_ff >= lx1_ff && nx6_ff <= hx1_ff &&
                   ny6_ff >= ly1_ff && ny6_ff <= hy1_ff;
   end

   assign out_valid = s7_v_ff;
   assign out_hit   = s7_hit_ff;

endmodule

FILE: rtl/core/segment_occlusion_test_core.sv
// ----------------------------------------------------------------------------
// segment_occlusion_test_core
// Line-of-sight test against a stored table of wall segments.
// ----------------------------------------------------------------------------
// Clear, append and unused-mode transactions need no scan: the response is
// valid in the cycle after acceptance. A query streams the stored walls from
// the wall RAM (through its registered read port) one per cycle, until a hit
// comes out, into a 7-stage intersection pipeline; after the end of the scan
// the pipeline drains in ST_DRAIN and ST_DONE returns the response.
// One transaction is worked at a time; a finished response waits in the
// output register, and the next request is taken only in a cycle where the
// response is taken or the register is empty.
module segment_occlusion_test_core
   import sot_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SCAN  = 4'b0010,
      ST_DRAIN = 4'b0100,
      ST_DONE  = 4'b1000
   } state_type;

   state_type         state_ff, state_in;
   logic [CountW-1:0] count_ff, count_in;
   logic [CountW-1:0] rd_idx_ff, rd_idx_in;
   logic              blocked_ff, blocked_in;
   seg_type           sight_ff, sight_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;
   logic              issue_ff;
   logic              issue;
   logic              wr_en;
   seg_type           wr_seg, rd_seg;
   logic              hit_valid, hit;
   logic [3:0]        drain_ff, drain_in;
   logic              accept;

   // output register frees when taken
   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign wr_seg    = '{x1: req_data.coord_ax, y1: req_data.coord_ay,
                        x2: req_data.coord_bx, y2: req_data.coord_by};
   assign wr_en     = accept && req_data.mode == MODE_APPEND &&
                      (req_data.wall_flags[0] | req_data.wall_kind[0]) &&
                      count_ff < CountW'(MaxWalls);
   assign issue     = (state_ff == ST_SCAN) && !blocked_ff && rd_idx_ff < count_ff;

   sot_wall_ram u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(count_ff[AddrW-1:0]),
      .wr_data(wr_seg),
      .rd_addr(rd_idx_ff[AddrW-1:0]),
      .rd_data(rd_seg)
   );

   sot_hit_pipe u_pipe (
      .clock    (clock),
      .reset    (reset),
      .in_valid (issue_ff),
      .wall     (rd_seg),
      .sight    (sight_ff),
      .out_valid(hit_valid),
      .out_hit  (hit)
   );

   // control sequencing
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      rd_idx_in    = rd_idx_ff;
      blocked_in   = blocked_ff || (hit_valid && hit);
      sight_in     = sight_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      drain_in     = drain_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_in = '{visible: 1'b0, walls_stored: count_ff, table_full: 1'b0};
               case (req_data.mode)
                  MODE_CLEAR: begin
                     count_in = '0;
                     rsp_in.walls_stored = '0;
                     rsp_valid_in = 1'b1;
                  end
                  MODE_APPEND: begin
                     if (wr_en) begin
                        count_in = count_ff + 1'b1;
                        rsp_in.walls_stored = count_ff + 1'b1;
                     end else if (req_data.wall_flags[0] | req_data.wall_kind[0]) begin
                        rsp_in.table_full = 1'b1;
                     end
                     rsp_valid_in = 1'b1;
                  end
                  MODE_QUERY: begin
                     sight_in   = wr_seg;
                     rd_idx_in  = '0;
                     blocked_in = 1'b0;
                     state_in   = ST_SCAN;
                  end
                  default: rsp_valid_in = 1'b1;
               endcase
            end
         end
         ST_SCAN: begin
            if (issue) begin
               rd_idx_in = rd_idx_ff + 1'b1;
            end else begin
               drain_in = 4'd9;
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            drain_in = drain_ff - 1'b1;
            if (drain_ff == 4'd0) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            rsp_in.visible = !blocked_ff;
            rsp_valid_in   = 1'b1;
            state_in       = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         issue_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         issue_ff     <= issue;
      end
      rd_idx_ff  <= rd_idx_in;
      blocked_ff <= blocked_in;
      sight_ff   <= sight_in;
      rsp_ff     <= rsp_in;
      drain_ff   <= drain_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // checks
   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CountW'(MaxWalls)) else $error("wall count overflow");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req_ready) else $error("accept while busy");
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      issue |-> rd_idx_ff < count_ff) else $error("read past table");
   a_done_resp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) |=> rsp_valid) else $error("query lost");

endmodule
